// ===== hw/rtl/acc_pkg.sv =====
// Package: constants, register codes and arithmetic helpers for the checkerboard compositor.
`timescale 1ns / 1ps
`default_nettype none

package acc_pkg;

   localparam int COORD_WIDTH = 16;
   localparam int CHAN_WIDTH  = 8;
   localparam int IN_WIDTH    = 2 * COORD_WIDTH + 4 * CHAN_WIDTH;
   localparam int OUT_WIDTH   = 3 * CHAN_WIDTH;
   localparam int CSR_IDX_WIDTH  = 2;
   localparam int CSR_DATA_WIDTH = 8;

   typedef enum logic [CSR_IDX_WIDTH-1:0] {
      CSR_CHECK_TYPE   = 2'd0,
      CSR_CHECK_SIZE   = 2'd1,
      CSR_OPACITY      = 2'd2,
      CSR_PIXEL_FORMAT = 2'd3
   } csr_index_type;

   typedef enum logic [1:0] {
      SIZE_SMALL  = 2'd0,
      SIZE_MEDIUM = 2'd1,
      SIZE_LARGE  = 2'd2
   } check_size_type;

   localparam logic [2:0] RESET_CHECK_TYPE   = 3'd1;
   localparam logic [1:0] RESET_CHECK_SIZE   = 2'd1;
   localparam logic [7:0] RESET_OPACITY      = 8'd255;
   localparam logic       RESET_PIXEL_FORMAT = 1'b0;
   localparam logic [7:0] FULL_SCALE         = 8'd255;

   function automatic logic [7:0] check_shade(input logic [2:0] ctype, input logic dark);
      logic [7:0] dark_level;
      logic [7:0] light_level;
      case (ctype)
         3'd0: begin
            dark_level  = 8'd204;
            light_level = 8'd255;
         end
         3'd1: begin
            dark_level  = 8'd102;
            light_level = 8'd153;
         end
         3'd2: begin
            dark_level  = 8'd0;
            light_level = 8'd51;
         end
         3'd3: begin
            dark_level  = 8'd255;
            light_level = 8'd255;
         end
         3'd4: begin
            dark_level  = 8'd127;
            light_level = 8'd127;
         end
         default: begin
            dark_level  = 8'd0;
            light_level = 8'd0;
         end
      endcase
      return dark ? dark_level : light_level;
   endfunction

   // exact floor(v / 255) for v up to 65279
   function automatic logic [7:0] div255(input logic [15:0] v);
      logic [16:0] t;
      t = {1'b0, v} + {9'd0, v[15:8]} + 17'd1;
      return t[15:8];
   endfunction

endpackage

`default_nettype wire

// ===== hw/rtl/alpha_checkerboard_composite.sv =====
// Top level: four-stage alpha composite of a pixel stream over a checkerboard.
//
//   channel  dir  handshake             payload
//   req      in   req_tvalid/req_tready req_tdata: pixel_x, pixel_y, red, green, blue, alpha
//   rsp      out  rsp_tvalid/rsp_tready rsp_tdata: out_red, out_green, out_blue
//   csr      in   csr_valid/csr_ready   csr_index, csr_data
//
// One beat per cycle while rsp_tready allows; an accepted beat is registered through
// v1_ff, v2_ff, v3_ff and v4_ff in order, and rsp_tvalid is v4_ff.
// Stages: opacity multiply, divide by 255, channel products and sum, divide by 255.
// Each stage holds its beat while the next is full and stalled; stalls drop nothing.
// reset empties the pipeline and restores register defaults; csr_ready stays high.
`timescale 1ns / 1ps
`default_nettype none

module alpha_checkerboard_composite (
   input  wire                                    clock,
   input  wire                                    reset,
   input  wire                                    req_tvalid,
   output logic                                   req_tready,
   // [15:0] pixel_x, [31:16] pixel_y, [39:32] red, [47:40] green,
   // [55:48] blue, [63:56] alpha
   input  wire  [acc_pkg::IN_WIDTH-1:0]           req_tdata,
   output logic                                   rsp_tvalid,
   input  wire                                    rsp_tready,
   // [7:0] out_red, [15:8] out_green, [23:16] out_blue
   output logic [acc_pkg::OUT_WIDTH-1:0]          rsp_tdata,
   input  wire                                    csr_valid,
   output logic                                   csr_ready,
   input  wire  [acc_pkg::CSR_IDX_WIDTH-1:0]      csr_index,
   input  wire  [acc_pkg::CSR_DATA_WIDTH-1:0]     csr_data
);

   localparam int CW = acc_pkg::COORD_WIDTH;

   logic [2:0] check_type_ff;
   logic [1:0] check_size_ff;
   logic [7:0] opacity_ff;
   logic       pixel_format_ff;

   logic [CW-1:0] pixel_x;
   logic [CW-1:0] pixel_y;
   logic [7:0]    red;
   logic [7:0]    green;
   logic [7:0]    blue;
   logic [7:0]    alpha;
   logic          dark;
   logic          rdy1;
   logic          rdy2;
   logic          rdy3;
   logic          rdy4;

   logic        v1_ff, v2_ff, v3_ff, v4_ff;
   logic [15:0] prod1_ff, prod1_in;
   logic [7:0]  shade1_ff, shade1_in;
   logic [7:0]  r1_ff, g1_ff, b1_ff, g1_in, b1_in;
   logic [7:0]  ea2_ff;
   logic [7:0]  shade2_ff;
   logic [7:0]  r2_ff, g2_ff, b2_ff;
   logic [15:0] sr3_ff, sg3_ff, sb3_ff, sr3_in, sg3_in, sb3_in;
   logic [15:0] bg_prod;
   logic [7:0]  or4_ff, og4_ff, ob4_ff;

   assign pixel_x = req_tdata[CW-1:0];
   assign pixel_y = req_tdata[2*CW-1:CW];
   assign red     = req_tdata[2*CW+7:2*CW];
   assign green   = req_tdata[2*CW+15:2*CW+8];
   assign blue    = req_tdata[2*CW+23:2*CW+16];
   assign alpha   = req_tdata[2*CW+31:2*CW+24];

   assign csr_ready = 1'b1;

   always_ff @(posedge clock) begin
      if (reset) begin
         check_type_ff   <= acc_pkg::RESET_CHECK_TYPE;
         check_size_ff   <= acc_pkg::RESET_CHECK_SIZE;
         opacity_ff      <= acc_pkg::RESET_OPACITY;
         pixel_format_ff <= acc_pkg::RESET_PIXEL_FORMAT;
      end else if (csr_valid) begin
         case (acc_pkg::csr_index_type'(csr_index))
            acc_pkg::CSR_CHECK_TYPE:   check_type_ff   <= csr_data[2:0];
            acc_pkg::CSR_CHECK_SIZE:   check_size_ff   <= csr_data[1:0];
            acc_pkg::CSR_OPACITY:      opacity_ff      <= csr_data;
            acc_pkg::CSR_PIXEL_FORMAT: pixel_format_ff <= csr_data[0];
            default: ;
         endcase
      end
   end

   assign rdy4       = !v4_ff || rsp_tready;
   assign rdy3       = !v3_ff || rdy4;
   assign rdy2       = !v2_ff || rdy3;
   assign rdy1       = !v1_ff || rdy2;
   assign req_tready = rdy1;

   always_comb begin
      case (acc_pkg::check_size_type'(check_size_ff))
         acc_pkg::SIZE_SMALL:  dark = pixel_x[2] ^ pixel_y[2];
         acc_pkg::SIZE_MEDIUM: dark = pixel_x[3] ^ pixel_y[3];
         default:              dark = pixel_x[4] ^ pixel_y[4];
      endcase
      shade1_in = acc_pkg::check_shade(check_type_ff, dark);
      prod1_in  = {8'd0, opacity_ff} * {8'd0, alpha};
      g1_in     = pixel_format_ff ? red : green;
      b1_in     = pixel_format_ff ? red : blue;
   end

   always_comb begin
      bg_prod = {8'd0, shade2_ff} * {8'd0, acc_pkg::FULL_SCALE - ea2_ff};
      sr3_in  = 16'(({8'd0, r2_ff} * {8'd0, ea2_ff}) + bg_prod);
      sg3_in  = 16'(({8'd0, g2_ff} * {8'd0, ea2_ff}) + bg_prod);
      sb3_in  = 16'(({8'd0, b2_ff} * {8'd0, ea2_ff}) + bg_prod);
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         v1_ff <= 1'b0;
         v2_ff <= 1'b0;
         v3_ff <= 1'b0;
         v4_ff <= 1'b0;
      end else begin
         if (rdy1) v1_ff <= req_tvalid;
         if (rdy2) v2_ff <= v1_ff;
         if (rdy3) v3_ff <= v2_ff;
         if (rdy4) v4_ff <= v3_ff;
      end
   end

   always_ff @(posedge clock) begin
      if (rdy1) begin
         prod1_ff  <= prod1_in;
         shade1_ff <= shade1_in;
         r1_ff     <= red;
         g1_ff     <= g1_in;
         b1_ff     <= b1_in;
      end
      if (rdy2) begin
         ea2_ff    <= acc_pkg::div255(prod1_ff);
         shade2_ff <= shade1_ff;
         r2_ff     <= r1_ff;
         g2_ff     <= g1_ff;
         b2_ff     <= b1_ff;
      end
      if (rdy3) begin
         sr3_ff <= sr3_in;
         sg3_ff <= sg3_in;
         sb3_ff <= sb3_in;
      end
      if (rdy4) begin
         or4_ff <= acc_pkg::div255(sr3_ff);
         og4_ff <= acc_pkg::div255(sg3_ff);
         ob4_ff <= acc_pkg::div255(sb3_ff);
      end
   end

   assign rsp_tvalid = v4_ff;
   assign rsp_tdata  = {ob4_ff, og4_ff, or4_ff};

endmodule

`default_nettype wire

// ===== hw/rtl/acc_checker.sv =====
// Checker: port-level properties of the checkerboard compositor, bound to the top level.
`timescale 1ns / 1ps
`default_nettype none

module acc_checker (
   input wire                                clock,
   input wire                                reset,
   input wire                                req_tvalid,
   input wire                                req_tready,
   input wire                                rsp_tvalid,
   input wire                                rsp_tready,
   input wire [acc_pkg::OUT_WIDTH-1:0]       rsp_tdata,
   input wire                                csr_ready
);

   a_rsp_hold: assert property (@(posedge clock) disable iff (reset)
      rsp_tvalid && !rsp_tready |=> rsp_tvalid && $stable(rsp_tdata))
      else $error("rsp beat dropped or changed while stalled");

   a_empty_after_reset: assert property (@(posedge clock)
      $past(reset) |-> !rsp_tvalid)
      else $error("rsp_tvalid high right after reset");

   a_csr_ready: assert property (@(posedge clock)
      !reset |-> csr_ready)
      else $error("csr_ready dropped");

   a_latency: assert property (@(posedge clock) disable iff (reset)
      (req_tvalid && req_tready) ##1 rsp_tready ##1 rsp_tready ##1 rsp_tready
      |=> rsp_tvalid)
      else $error("accepted beat missing at output after four cycles");

endmodule

bind alpha_checkerboard_composite acc_checker u_acc_checker (
   .clock      (clock),
   .reset      (reset),
   .req_tvalid (req_tvalid),
   .req_tready (req_tready),
   .rsp_tvalid (rsp_tvalid),
   .rsp_tready (rsp_tready),
   .rsp_tdata  (rsp_tdata),
   .csr_ready  (csr_ready)
);

`default_nettype wire

// ===== test/tb_top.sv =====
// Self-checking testbench for the checkerboard alpha compositor, with an in-bench predictor.
`timescale 1ns / 1ps

module tb_top;

   localparam int IDLE_LIMIT  = 2000;
   localparam int HOLD_CYCLES = 300;
   localparam int PHASE_BEATS = 50;
   localparam int NUM_PHASES  = 12;
   localparam int REPORT_MAX  = 10;

   localparam logic [7:0] DARK_LEVEL [0:5]  = '{8'd204, 8'd102, 8'd0, 8'd255, 8'd127, 8'd0};
   localparam logic [7:0] LIGHT_LEVEL [0:5] = '{8'd255, 8'd153, 8'd51, 8'd255, 8'd127, 8'd0};

   typedef struct packed {
      logic [7:0]                      alpha;
      logic [7:0]                      blue;
      logic [7:0]                      green;
      logic [7:0]                      red;
      logic [acc_pkg::COORD_WIDTH-1:0] pixel_y;
      logic [acc_pkg::COORD_WIDTH-1:0] pixel_x;
   } pixel_beat_type;

   typedef struct packed {
      logic [7:0] out_blue;
      logic [7:0] out_green;
      logic [7:0] out_red;
   } rgb_beat_type;

   logic                               clock = 1'b0;
   logic                               reset = 1'b1;
   logic                               req_tvalid = 1'b0;
   logic                               req_tready;
   logic [acc_pkg::IN_WIDTH-1:0]       req_tdata = '0;
   logic                               rsp_tvalid;
   logic                               rsp_tready = 1'b0;
   logic [acc_pkg::OUT_WIDTH-1:0]      rsp_tdata;
   logic                               csr_valid = 1'b0;
   logic                               csr_ready;
   logic [acc_pkg::CSR_IDX_WIDTH-1:0]  csr_index = '0;
   logic [acc_pkg::CSR_DATA_WIDTH-1:0] csr_data = '0;

   // predictor copy of the registers
   logic [2:0] cfg_check_type   = acc_pkg::RESET_CHECK_TYPE;
   logic [1:0] cfg_check_size   = acc_pkg::RESET_CHECK_SIZE;
   logic [7:0] cfg_opacity      = acc_pkg::RESET_OPACITY;
   logic       cfg_pixel_format = acc_pkg::RESET_PIXEL_FORMAT;

   rgb_beat_type expected_rgb[$];
   int           error_count     = 0;
   int           reported        = 0;
   int           pixels_sent     = 0;
   int           writes_done     = 0;
   int           results_checked = 0;
   int           idle_cycles     = 0;
   int           hold_left       = 0;
   logic         hold_pending    = 1'b0;
   logic         req_gaps        = 1'b1;
   logic         rsp_gaps        = 1'b1;

   alpha_checkerboard_composite i_dut (
      .clock      (clock),
      .reset      (reset),
      .req_tvalid (req_tvalid),
      .req_tready (req_tready),
      .req_tdata  (req_tdata),
      .rsp_tvalid (rsp_tvalid),
      .rsp_tready (rsp_tready),
      .rsp_tdata  (rsp_tdata),
      .csr_valid  (csr_valid),
      .csr_ready  (csr_ready),
      .csr_index  (csr_index),
      .csr_data   (csr_data)
   );

   initial begin
      forever #5 clock = ~clock;
   end

   function automatic logic [7:0] mix_level(input int c, input int ea, input int shade);
      return 8'((c * ea + shade * (255 - ea)) / 255);
   endfunction

   function automatic rgb_beat_type blend_pixel(input pixel_beat_type p);
      int            shift;
      int            ea;
      int            shade;
      int            kind;
      logic          odd;
      rgb_beat_type  r;
      case (cfg_check_size)
         acc_pkg::SIZE_SMALL:  shift = 2;
         acc_pkg::SIZE_MEDIUM: shift = 3;
         default:              shift = 4;
      endcase
      kind  = (cfg_check_type > 3'd5) ? 5 : int'(cfg_check_type);
      odd   = p.pixel_x[shift] ^ p.pixel_y[shift];
      shade = odd ? int'(DARK_LEVEL[kind]) : int'(LIGHT_LEVEL[kind]);
      ea    = (int'(cfg_opacity) * int'(p.alpha)) / 255;
      r.out_red = mix_level(int'(p.red), ea, shade);
      if (cfg_pixel_format) begin
         r.out_green = r.out_red;
         r.out_blue  = r.out_red;
      end else begin
         r.out_green = mix_level(int'(p.green), ea, shade);
         r.out_blue  = mix_level(int'(p.blue), ea, shade);
      end
      return r;
   endfunction

   function automatic pixel_beat_type make_pixel(input logic [15:0] x, input logic [15:0] y,
                                                 input logic [7:0] r, input logic [7:0] g,
                                                 input logic [7:0] b, input logic [7:0] a);
      pixel_beat_type p;
      p.pixel_x = x;
      p.pixel_y = y;
      p.red     = r;
      p.green   = g;
      p.blue    = b;
      p.alpha   = a;
      return p;
   endfunction

   function automatic logic [7:0] random_level();
      case ($urandom_range(0, 7))
         0:       return 8'd0;
         1:       return 8'd255;
         default: return 8'($urandom_range(0, 255));
      endcase
   endfunction

   function automatic pixel_beat_type random_pixel();
      return make_pixel(16'($urandom), 16'($urandom), random_level(), random_level(),
                        random_level(), random_level());
   endfunction

   // drive one pixel beat; tvalid stays high after acceptance
   task automatic send_pixel(input pixel_beat_type p);
      @(negedge clock);
      while (req_gaps && $urandom_range(0, 99) < 28) begin
         req_tvalid <= 1'b0;
         @(negedge clock);
      end
      req_tvalid <= 1'b1;
      req_tdata  <= p;
      do @(posedge clock); while (!req_tready);
      expected_rgb.push_back(blend_pixel(p));
      pixels_sent++;
   endtask

   task automatic drain_pipe();
      @(negedge clock);
      req_tvalid <= 1'b0;
      while (expected_rgb.size() != 0) @(posedge clock);
      repeat (6) @(posedge clock);
   endtask

   task automatic write_reg(input acc_pkg::csr_index_type idx, input logic [7:0] value);
      drain_pipe();
      @(negedge clock);
      csr_valid <= 1'b1;
      csr_index <= idx;
      csr_data  <= value;
      do @(posedge clock); while (!csr_ready);
      case (idx)
         acc_pkg::CSR_CHECK_TYPE:   cfg_check_type   = value[2:0];
         acc_pkg::CSR_CHECK_SIZE:   cfg_check_size   = value[1:0];
         acc_pkg::CSR_OPACITY:      cfg_opacity      = value;
         acc_pkg::CSR_PIXEL_FORMAT: cfg_pixel_format = value[0];
         default: ;
      endcase
      writes_done++;
      @(negedge clock);
      csr_valid <= 1'b0;
   endtask

   task automatic test_reset_defaults();
      send_pixel(make_pixel(16'd0, 16'd0, 8'd0, 8'd0, 8'd0, 8'd0));
      send_pixel(make_pixel(16'hFFFF, 16'hFFFF, 8'd255, 8'd255, 8'd255, 8'd255));
      send_pixel(make_pixel(16'd8, 16'd0, 8'd255, 8'd0, 8'd128, 8'd0));
      send_pixel(make_pixel(16'hFFFF, 16'd0, 8'd17, 8'd200, 8'd90, 8'd128));
   endtask

   // every pair, plus the two out-of-range codes that saturate to the last pair
   task automatic test_check_types();
      for (int t = 0; t < 8; t++) begin
         write_reg(acc_pkg::CSR_CHECK_TYPE, 8'(t));
         send_pixel(make_pixel(16'((t % 2) * 8), 16'd0, 8'd255, 8'd255, 8'd255, 8'd0));
      end
   endtask

   // x has bits 2 and 4 set, so parity flips with the check size; size three acts as large
   task automatic test_check_sizes();
      write_reg(acc_pkg::CSR_CHECK_TYPE, 8'd0);
      for (int s = 0; s < 4; s++) begin
         write_reg(acc_pkg::CSR_CHECK_SIZE, 8'(s));
         send_pixel(make_pixel(16'h0014, 16'd0, 8'd10, 8'd20, 8'd30, 8'd64));
      end
   endtask

   task automatic test_opacity_and_gray();
      write_reg(acc_pkg::CSR_OPACITY, 8'd0);
      send_pixel(make_pixel(16'd3, 16'd40, 8'd255, 8'd255, 8'd255, 8'd255));
      write_reg(acc_pkg::CSR_OPACITY, 8'd255);
      send_pixel(make_pixel(16'd3, 16'd40, 8'd255, 8'd0, 8'd255, 8'd255));
      write_reg(acc_pkg::CSR_PIXEL_FORMAT, 8'd1);
      send_pixel(make_pixel(16'd100, 16'd7, 8'd200, 8'd0, 8'd255, 8'd100));
      send_pixel(make_pixel(16'd0, 16'hFFFF, 8'd0, 8'd255, 8'd0, 8'd255));
      write_reg(acc_pkg::CSR_PIXEL_FORMAT, 8'd0);
   endtask

   task automatic test_random_phases();
      for (int ph = 0; ph < NUM_PHASES; ph++) begin
         if (ph == 0) begin
            write_reg(acc_pkg::CSR_CHECK_TYPE, 8'd0);
            write_reg(acc_pkg::CSR_CHECK_SIZE, 8'd0);
            write_reg(acc_pkg::CSR_OPACITY, 8'd0);
            write_reg(acc_pkg::CSR_PIXEL_FORMAT, 8'd0);
         end else if (ph == 1) begin
            write_reg(acc_pkg::CSR_CHECK_TYPE, 8'd7);
            write_reg(acc_pkg::CSR_CHECK_SIZE, 8'd3);
            write_reg(acc_pkg::CSR_OPACITY, 8'd255);
            write_reg(acc_pkg::CSR_PIXEL_FORMAT, 8'd1);
         end else begin
            write_reg(acc_pkg::CSR_CHECK_TYPE, 8'($urandom_range(0, 255)));
            write_reg(acc_pkg::CSR_CHECK_SIZE, 8'($urandom_range(0, 255)));
            write_reg(acc_pkg::CSR_OPACITY, random_level());
            write_reg(acc_pkg::CSR_PIXEL_FORMAT, 8'($urandom_range(0, 255)));
         end
         req_gaps = (ph != 5);
         rsp_gaps = (ph != 5);
         for (int i = 0; i < PHASE_BEATS; i++) send_pixel(random_pixel());
      end
      req_gaps = 1'b1;
      rsp_gaps = 1'b1;
   endtask

   // stall the receiver long enough that the pipeline fills and stalls the sender
   task automatic test_backpressure();
      write_reg(acc_pkg::CSR_CHECK_TYPE, 8'd2);
      write_reg(acc_pkg::CSR_OPACITY, 8'd180);
      hold_pending = 1'b1;
      for (int i = 0; i < 40; i++) send_pixel(random_pixel());
   endtask

   always @(negedge clock) begin
      if (hold_pending) begin
         hold_pending = 1'b0;
         hold_left    = HOLD_CYCLES;
      end
      if (hold_left > 0) begin
         hold_left--;
         rsp_tready <= 1'b0;
      end else if (rsp_gaps) begin
         rsp_tready <= ($urandom_range(0, 99) >= 28);
      end else begin
         rsp_tready <= 1'b1;
      end
   end

   always @(posedge clock) begin
      rgb_beat_type got;
      rgb_beat_type want;
      if (!reset && rsp_tvalid && rsp_tready) begin
         got = rsp_tdata;
         results_checked++;
         if (expected_rgb.size() == 0) begin
            error_count++;
            if (reported < REPORT_MAX) begin
               reported++;
               $display("unexpected beat r=%0d g=%0d b=%0d", got.out_red, got.out_green,
                        got.out_blue);
            end
         end else begin
            want = expected_rgb.pop_front();
            if (got.out_red != want.out_red || got.out_green != want.out_green ||
                got.out_blue != want.out_blue) begin
               error_count++;
               if (reported < REPORT_MAX) begin
                  reported++;
                  $display("mismatch on beat %0d: expected r=%0d g=%0d b=%0d",
                           results_checked, want.out_red, want.out_green, want.out_blue);
                  $display("   got r=%0d g=%0d b=%0d",
                           got.out_red, got.out_green, got.out_blue);
               end
            end
         end
      end
   end

   initial begin
      while (idle_cycles < IDLE_LIMIT) begin
         @(posedge clock);
         if ((req_tvalid && req_tready) || (rsp_tvalid && rsp_tready) ||
             (csr_valid && csr_ready) || reset)
            idle_cycles = 0;
         else
            idle_cycles++;
      end
      $display("timeout: no beat accepted for %0d cycles", IDLE_LIMIT);
      $display("Testbench completed WITH ERRORS");
      $finish;
   end

   initial begin
      repeat (10) @(posedge clock);
      @(negedge clock);
      reset <= 1'b0;
      test_reset_defaults();
      test_check_types();
      test_check_sizes();
      test_opacity_and_gray();
      test_random_phases();
      test_backpressure();
      drain_pipe();
      repeat (10) @(posedge clock);
      if (expected_rgb.size() != 0) error_count++;
      $display("Sent %0d pixels across %0d register writes: all check pairs and sizes,",
               pixels_sent, writes_done);
      $display("opacity extremes, RGBA and gray, long output stall; %0d checked, %0d bad.",
               results_checked, error_count);
      if (error_count == 0)
         $display("Testbench completed without errors");
      else
         $display("Testbench completed WITH ERRORS");
      $finish;
   end

endmodule
